/* sv/base64_stream_encoder_unit_macros.svh */
// Assertion helpers used by the encoder unit to check itself.
`ifndef BASE64_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE64_STREAM_ENCODER_UNIT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define B64E_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64e: implication check failed");

// Condition must never be seen.
`define B64E_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("b64e: forbidden condition seen");

`endif

/* sv/b64e_pkg.sv */
package b64e_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam logic [6:0] CHAR_PAD   = 7'h3D;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_SLASH = 7'h2F;
    localparam logic [6:0] CHAR_UP_A  = 7'h41;
    localparam logic [6:0] CHAR_UP_Z  = 7'h5A;
    localparam logic [6:0] CHAR_LO_A  = 7'h61;
    localparam logic [6:0] CHAR_LO_Z  = 7'h7A;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_NINE  = 7'h39;

    // One three-byte group ready for encoding.
    typedef struct packed {
        logic [23:0] bytes;  // first byte in bits 23:16, unused bytes zero
        logic [1:0]  have;   // number of real bytes, 1..3
        logic        fin;    // group closes the message
    } t_group;

    // Queue status seen by the input handshake, the back end and the checks.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] w;
        logic [6:0] r;
        w = {1'b0, v};
        if (v < 6'd26) begin
            r = CHAR_UP_A + w;
        end else if (v < 6'd52) begin
            r = CHAR_LO_A + w - 7'd26;
        end else if (v < 6'd62) begin
            r = CHAR_ZERO + w - 7'd52;
        end else if (v == 6'd62) begin
            r = CHAR_PLUS;
        end else begin
            r = CHAR_SLASH;
        end
        return r;
    endfunction

    function automatic logic is_code_char(input logic [6:0] c);
        return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ||
               ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)) ||
               ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
               (c == CHAR_PLUS) || (c == CHAR_SLASH) || (c == CHAR_PAD);
    endfunction

endpackage

/* sv/b64e_front.sv */
module b64e_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_final,
    output logic              o_push,
    output b64e_pkg::t_group  o_group
);

    logic [15:0] r_held;
    logic [1:0]  r_cnt;
    logic [15:0] n_held;
    logic [1:0]  n_cnt;
    logic [1:0]  cnt;

    // A count of three never occurs; treat it as empty.
    assign cnt = (r_cnt == 2'd3) ? 2'd0 : r_cnt;

    always_comb begin
        unique case (cnt)
            2'd1:    o_group.bytes = {r_held[15:8], i_byte, 8'h00};
            2'd2:    o_group.bytes = {r_held, i_byte};
            default: o_group.bytes = {i_byte, 16'h0000};
        endcase
        o_group.have = cnt + 2'd1;
        o_group.fin  = i_final;
    end

    assign o_push = i_accept && ((cnt == 2'd2) || i_final);

    always_comb begin
        n_held = r_held;
        n_cnt  = r_cnt;
        if (o_push) begin
            n_held = '0;
            n_cnt  = '0;
        end else if (i_accept) begin
            n_held = o_group.bytes[23:8];
            n_cnt  = cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_cnt  <= '0;
        end else begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

endmodule

/* sv/b64e_fifo.sv */
module b64e_fifo #(
    parameter int DEPTH = b64e_pkg::FIFO_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64e_pkg::t_group     i_group,
    input  logic                 i_pop,
    output b64e_pkg::t_group     o_group,
    output b64e_pkg::t_fifo_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_group      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* sv/b64e_back.sv */
module b64e_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  b64e_pkg::t_group i_group,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [6:0]       o_char,
    output logic             o_last
);

    b64e_pkg::t_group r_grp;
    logic             r_gvalid;
    logic [1:0]       r_idx;
    logic             r_ovalid;
    logic [6:0]       r_ochar;
    logic             r_olast;
    logic             out_free;
    logic [5:0]       sextet;
    logic             pad;
    logic [6:0]       cur_char;

    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = i_avail && (!r_gvalid || (out_free && (r_idx == 2'd3)));

    always_comb begin
        unique case (r_idx)
            2'd0: begin
                sextet = r_grp.bytes[23:18];
                pad    = 1'b0;
            end
            2'd1: begin
                sextet = r_grp.bytes[17:12];
                pad    = 1'b0;
            end
            2'd2: begin
                sextet = r_grp.bytes[11:6];
                pad    = (r_grp.have < 2'd2);
            end
            2'd3: begin
                sextet = r_grp.bytes[5:0];
                pad    = (r_grp.have < 2'd3);
            end
        endcase
        cur_char = pad ? b64e_pkg::CHAR_PAD : b64e_pkg::sextet_char(sextet);
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_ochar <= cur_char;
            r_olast <= r_grp.fin && (r_idx == 2'd3);
        end
        if (o_pop) begin
            r_grp <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvalid <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) begin
                r_ovalid <= r_gvalid;
            end
            if (o_pop) begin
                r_gvalid <= 1'b1;
                r_idx    <= '0;
            end else if (out_free && r_gvalid) begin
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    r_gvalid <= 1'b0;
                end
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;

endmodule

/* sv/base64_stream_encoder_unit.sv */
// Channel   Dir  Transfer carries
// --------  ---  ----------------------------------------------------
// s (in)    in   one raw byte; tlast marks the last byte of a message
// m (out)   out  one ASCII base64 character or '='; tlast on the last
//
// Flow: a byte is taken whenever the group queue has room; each closed group
// leaves as four characters, one per cycle while m is ready. The first character
// of a group passes through the group queue, the group register and the output
// register.
// Reset: synchronous, active low; clears the held bytes, queue and output stage.
// A stall on m backs up into the group queue and then holds s_tready low.
`include "base64_stream_encoder_unit_macros.svh"

module base64_stream_encoder_unit #(
    parameter int FIFO_DEPTH = b64e_pkg::FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // final_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] code_char, [7] zero
    output logic       o_m_tlast    // last_char
);

    logic                 s_accept;
    logic                 push;
    logic                 pop;
    b64e_pkg::t_group     front_group;
    b64e_pkg::t_group     head_group;
    b64e_pkg::t_fifo_stat fifo_stat;
    logic [6:0]           out_char;

    // Accept a byte only while the queue has room for a group, also when the
    // byte just goes into the hold register.
    assign o_s_tready = !fifo_stat.full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(s_accept),
        .i_byte  (i_s_tdata),
        .i_final (i_s_tlast),
        .o_push  (push),
        .o_group (front_group)
    );

    b64e_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (front_group),
        .i_pop   (pop),
        .o_group (head_group),
        .o_stat  (fifo_stat)
    );

    // Drain one group into four characters through the output register.
    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!fifo_stat.empty),
        .i_group (head_group),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_char  (out_char),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, out_char};

    `B64E_ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, push && fifo_stat.full)
    `B64E_ASSERT_NEVER(a_pop_when_empty, i_clk, i_rst_n, pop && fifo_stat.empty)
    `B64E_ASSERT_NEVER(a_full_and_empty, i_clk, i_rst_n, fifo_stat.full && fifo_stat.empty)
    `B64E_ASSERT_IMPLIES(a_char_legal, i_clk, i_rst_n, o_m_tvalid, b64e_pkg::is_code_char(out_char))

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 9;
    // Longest legal quiet spell is the long hold-off below plus a few long gaps.
    localparam int STUCK_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int REPORT_LIMIT    = 10;
    localparam int RANDOM_ITEMS    = 410;
    localparam int HOLD_OFF_CYCLES = 300;

    // One expected character on the output stream.
    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_b64_char;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;   // [7:0] data_byte
    logic       i_s_tlast  = 1'b0;    // final_byte
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;            // [6:0] code_char, [7] zero
    logic       o_m_tlast;            // last_char

    // Encoder state mirrored on the bench side.
    logic [15:0] held_pair = 16'h0000;
    logic [1:0]  held_n    = 2'd0;

    t_b64_char   pending_chars[$];
    logic [7:0]  message_bytes[$];

    int mismatches      = 0;
    int stuck_cycles    = 0;
    int sink_hold_left  = 0;
    int sink_stall_left = 0;
    bit src_steady      = 1'b0;
    bit sink_steady     = 1'b0;

    base64_stream_encoder_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Map a six-bit value onto the standard alphabet.
    function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
        string alphabet = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                           "abcdefghijklmnopqrstuvwxyz", "0123456789+/"};
        byte   c;
        c = alphabet[v];
        return c[6:0];
    endfunction

    // Mostly short gaps, now and then a long one; never zero.
    function automatic int gap_length();
        if ($urandom_range(0, 9) < 9) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Fold one accepted byte into the mirrored state and queue the
    // characters it releases, if any.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] n;
        int         have;
        logic [6:0] c[4];

        // A count of three never occurs; treat it as an empty group.
        n  = (held_n > 2'd2) ? 2'd0 : held_n;
        b0 = (n == 2'd0) ? b : held_pair[15:8];
        b1 = (n == 2'd0) ? 8'h00 : ((n == 2'd1) ? b : held_pair[7:0]);
        b2 = (n == 2'd2) ? b : 8'h00;
        have = n + 1;

        if (have < 3 && !fin) begin
            // Group still filling: hold the byte, release nothing.
            held_pair = (n == 2'd0) ? {b0, 8'h00} : {b0, b1};
            held_n    = have[1:0];
        end else begin
            c[0] = sextet_to_ascii(b0[7:2]);
            c[1] = sextet_to_ascii({b0[1:0], b1[7:4]});
            c[2] = (have >= 2) ? sextet_to_ascii({b1[3:0], b2[7:6]}) : b64e_pkg::CHAR_PAD;
            c[3] = (have >= 3) ? sextet_to_ascii(b2[5:0]) : b64e_pkg::CHAR_PAD;
            for (int k = 0; k < 4; k++) begin
                pending_chars.push_back('{code: c[k], last: fin && (k == 3)});
            end
            held_pair = 16'h0000;
            held_n    = 2'd0;
        end
    endtask

    // Offer one byte after an optional gap and hold it until transfer.
    // Entered and left at a falling edge; valid stays high when the next
    // byte follows without a gap.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (src_steady || $urandom_range(0, 1) == 0) ? 0 : gap_length();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        encode_byte(b, fin);
        @(negedge i_clk);
    endtask

    // Send message_bytes as one message, final flag on its last byte.
    task automatic send_message();
        int len;
        len = message_bytes.size();
        for (int i = 0; i < len; i++) begin
            send_byte(message_bytes[i], i == len - 1);
        end
        message_bytes.delete();
    endtask

    task automatic note_mismatch(input string what, input logic [8:0] want,
                                 input logic [8:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s: expected code/last %h/%b, got %h/%b",
                     $realtime, what, want[8:1], want[0], got[8:1], got[0]);
        end
    endtask

    // Extremes of the byte, every group shape, digits and both symbols.
    task automatic test_directed();
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        // Final byte as first of a group: two characters then two pads.
        message_bytes = '{8'h00};
        send_message();
        message_bytes = '{8'hFF};
        send_message();
        // Final byte as second of a group: three characters then one pad.
        message_bytes = '{8'h00, 8'hFF};
        send_message();
        message_bytes = '{8'hFF, 8'h00};
        send_message();
        // Group completes on the final byte; '+' and '/' both appear.
        message_bytes = '{8'hFB, 8'hFF, 8'hBF};
        send_message();
        // Full group without final, then a full group closing the message.
        message_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF};
        send_message();
        message_bytes = '{8'h4D, 8'h61, 8'h6E, 8'h4D, 8'h61};
        send_message();
        // Digits range of the alphabet.
        message_bytes = '{8'hD3, 8'h5D, 8'hB7};
        send_message();
    endtask

    // Hold the receiver off for a long stretch while bytes keep coming,
    // so the group queue fills and the input stalls.
    task automatic test_backpressure();
        src_steady     = 1'b1;
        sink_hold_left = HOLD_OFF_CYCLES;
        for (int i = 0; i < 40; i++) begin
            message_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_message();
        src_steady = 1'b0;
    endtask

    // Well-formed messages of random length and content; some of them run
    // with no idling on either side.
    task automatic test_random_messages();
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(1, 9);
            end else if (pick < 95) begin
                len = $urandom_range(10, 30);
            end else begin
                len = $urandom_range(31, 60);
            end
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    message_bytes.push_back(8'h00);
                end else if (pick == 1) begin
                    message_bytes.push_back(8'hFF);
                end else begin
                    message_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            send_message();
            sent += len;
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Receiver: a long hold-off when asked, else random stalls.
    always @(negedge i_clk) begin
        if (sink_hold_left > 0) begin
            i_m_tready <= 1'b0;
            sink_hold_left = sink_hold_left - 1;
        end else if (sink_stall_left > 0) begin
            i_m_tready <= 1'b0;
            sink_stall_left = sink_stall_left - 1;
        end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
            i_m_tready <= 1'b0;
            sink_stall_left = gap_length() - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Compare every output transfer with the oldest expected character.
    always @(posedge i_clk) begin : check_chars
        t_b64_char want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_chars.size() == 0) begin
                note_mismatch("unexpected character", 9'h000, {o_m_tdata, o_m_tlast});
            end else begin
                want = pending_chars.pop_front();
                if (o_m_tdata !== {1'b0, want.code} || o_m_tlast !== want.last) begin
                    note_mismatch("wrong character", {1'b0, want.code, want.last},
                                  {o_m_tdata, o_m_tlast});
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("base64_stream_encoder_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_backpressure();
        test_random_messages();

        // Drop valid, drain what is still expected, then let the pipe settle.
        i_s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("base64_stream_encoder_unit: match");
        end else begin
            $display("base64_stream_encoder_unit: mismatch");
        end
        $finish;
    end

endmodule
